@@ hdl/pfla_pkg.sv @@
// ============================================================================
// pfla_pkg
// Shared types and constants for the paged free list allocator.
// ============================================================================
package pfla_pkg;

    // pool geometry
    localparam int unsigned MAX_SLOTS = 1024;
    localparam int unsigned SLOT_W    = $clog2(MAX_SLOTS);
    localparam int unsigned CNT_W     = 11;
    localparam int unsigned CHAIN_W   = SLOT_W + 1;

    // configuration fields
    localparam int unsigned PAGE_W    = 11;
    localparam int unsigned OBJ_W     = 13;
    localparam int unsigned OFFSET_W  = 22;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [PAGE_W-1:0] PAGE_SLOTS_RST   = PAGE_W'(64);
    localparam logic [OBJ_W-1:0]  OBJECT_BYTES_RST = OBJ_W'(8);
    localparam logic [OBJ_W-1:0]  MIN_OBJ_BYTES    = OBJ_W'(8);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SLOTS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_BYTES = CFG_IDX_W'(1);

    // commands
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // status codes
    localparam logic STATUS_OK           = 1'b0;
    localparam logic STATUS_OUT_OF_SPACE = 1'b1;

    // one free list link: slot index plus a flag that the link is live
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] idx;
    } link_t;

endpackage

@@ hdl/paged_free_list_allocator_unit.sv @@
// ============================================================================
// paged_free_list_allocator_unit
// Fixed-size slot allocator with a LIFO free list held as next links in RAM.
// ============================================================================
// Usage:
//   s_ channel takes one command per transaction: allocate (pop the head
//   slot) or release (push s_slot_in). Every command yields exactly one
//   m_ transaction with slot, byte offset, status and pool counters.
//   cfg_ channel writes page_slots and object_bytes; write only while idle.
// Command steps:
//   release: the link write when the command is accepted, then the result load.
//   allocate from a non-empty list: the link RAM is read at the head slot
//   when the command is accepted, then the result load moves the head.
//   allocate from an empty list: chains a new page first, one link write
//   per cycle, then the head read, then the result load.
//   An allocate that finds no room for a page returns out_of_space.
// Reset:
//   the list is empty, counters are zero, page_slots is 64, object_bytes
//   is 8. The link RAM needs no clearing: every entry is written before
//   the list can reach it.
// Stalls:
//   a result sits in the output register until taken; the next command is
//   accepted meanwhile and its work waits at the result stage.
// ============================================================================
module paged_free_list_allocator_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // command channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_command,
    input  logic [pfla_pkg::SLOT_W-1:0]      s_slot_in,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [pfla_pkg::SLOT_W-1:0]      m_slot_out,
    output logic [pfla_pkg::OFFSET_W-1:0]    m_byte_offset,
    output logic                             m_status,
    output logic [pfla_pkg::CNT_W-1:0]       m_pages_used,
    output logic [pfla_pkg::CNT_W-1:0]       m_items_out,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pfla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfla_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pfla_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_DONE
    } state_t;

    state_t               state_reg;
    link_t                head_reg;
    logic [CNT_W-1:0]     page_count_reg;
    logic [CNT_W-1:0]     handed_out_reg;
    logic [CHAIN_W-1:0]   chained_reg;
    logic [PAGE_W-1:0]    page_slots_reg;
    logic [OBJ_W-1:0]     object_bytes_reg;

    logic [SLOT_W-1:0]    slot_reg;
    logic                 status_reg;
    logic                 pop_reg;
    logic [SLOT_W-1:0]    fill_addr_reg;
    logic [SLOT_W-1:0]    fill_base_reg;
    logic [SLOT_W-1:0]    fill_last_reg;

    logic                 m_valid_reg;
    logic [SLOT_W-1:0]    m_slot_out_reg;
    logic [OFFSET_W-1:0]  m_byte_offset_reg;
    logic                 m_status_reg;
    logic [CNT_W-1:0]     m_pages_used_reg;
    logic [CNT_W-1:0]     m_items_out_reg;

    // link memory
    link_t                link_mem [MAX_SLOTS];
    link_t                rd_data_reg;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_waddr;
    link_t                mem_wdata;
    logic                 mem_re;

    logic                 s_accept;
    logic                 out_free;
    logic [PAGE_W-1:0]    page_n;
    logic [CHAIN_W:0]     chain_end;
    logic                 page_fits;
    logic [OBJ_W-1:0]     eff_bytes;
    logic [SLOT_W+OBJ_W-1:0] product;
    logic [CNT_W-1:0]     handed_inc;
    logic [CNT_W-1:0]     handed_dec;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // page size and room check for a new page
    assign page_n    = (page_slots_reg == '0) ? PAGE_W'(1) : page_slots_reg;
    assign chain_end = (CHAIN_W+1)'(chained_reg) + (CHAIN_W+1)'(page_n);
    assign page_fits = (chain_end <= (CHAIN_W+1)'(MAX_SLOTS));

    // offset multiplier, fed from a register and loaded into the output register
    assign eff_bytes = (object_bytes_reg < MIN_OBJ_BYTES) ? MIN_OBJ_BYTES : object_bytes_reg;
    assign product   = (SLOT_W+OBJ_W)'(slot_reg) * (SLOT_W+OBJ_W)'(eff_bytes);

    // saturating item counts
    assign handed_inc = (handed_out_reg == '1) ? handed_out_reg : handed_out_reg + CNT_W'(1);
    assign handed_dec = (handed_out_reg == '0) ? handed_out_reg : handed_out_reg - CNT_W'(1);

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = s_slot_in;
        mem_wdata = head_reg;
        if (state_reg == ST_IDLE && s_accept && s_command == CMD_RELEASE) begin
            mem_we = 1'b1;
        end else if (state_reg == ST_FILL) begin
            mem_we    = 1'b1;
            mem_waddr = fill_addr_reg;
            if (fill_addr_reg == fill_base_reg) begin
                mem_wdata = '{valid: 1'b0, idx: '0};
            end else begin
                mem_wdata = '{valid: 1'b1, idx: fill_addr_reg - SLOT_W'(1)};
            end
        end
        mem_re = (state_reg == ST_READ) ||
                 (s_accept && s_command == CMD_ALLOC && head_reg.valid);
    end

    // link memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= link_mem[head_reg.idx];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_slots_reg   <= PAGE_SLOTS_RST;
            object_bytes_reg <= OBJECT_BYTES_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PAGE_SLOTS:   page_slots_reg   <= cfg_data[PAGE_W-1:0];
                REG_OBJECT_BYTES: object_bytes_reg <= cfg_data[OBJ_W-1:0];
                default: ;
            endcase
        end
    end

    // command sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '{valid: 1'b0, idx: '0};
            page_count_reg <= '0;
            handed_out_reg <= '0;
            chained_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // a result load in the done state keeps valid high
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (s_command == CMD_RELEASE) begin
                            pop_reg        <= 1'b0;
                            slot_reg       <= '0;
                            status_reg     <= STATUS_OK;
                            head_reg       <= '{valid: 1'b1, idx: s_slot_in};
                            handed_out_reg <= handed_dec;
                            state_reg      <= ST_DONE;
                        end else if (head_reg.valid) begin
                            // read issued this edge at the head slot
                            slot_reg   <= head_reg.idx;
                            pop_reg    <= 1'b1;
                            status_reg <= STATUS_OK;
                            state_reg  <= ST_DONE;
                        end else if (page_fits) begin
                            pop_reg       <= 1'b0;
                            status_reg    <= STATUS_OK;
                            fill_base_reg <= chained_reg[SLOT_W-1:0];
                            fill_addr_reg <= chained_reg[SLOT_W-1:0];
                            fill_last_reg <= SLOT_W'(chain_end - (CHAIN_W+1)'(1));
                            state_reg     <= ST_FILL;
                        end else begin
                            pop_reg    <= 1'b0;
                            slot_reg   <= '0;
                            status_reg <= STATUS_OUT_OF_SPACE;
                            state_reg  <= ST_DONE;
                        end
                    end
                end
                ST_FILL: begin
                    // one link written per cycle
                    if (fill_addr_reg == fill_last_reg) begin
                        head_reg       <= '{valid: 1'b1, idx: fill_last_reg};
                        chained_reg    <= CHAIN_W'(fill_last_reg) + CHAIN_W'(1);
                        page_count_reg <= page_count_reg + CNT_W'(1);
                        state_reg      <= ST_READ;
                    end else begin
                        fill_addr_reg <= fill_addr_reg + SLOT_W'(1);
                    end
                end
                ST_READ: begin
                    slot_reg  <= head_reg.idx;
                    pop_reg   <= 1'b1;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg       <= 1'b1;
                        m_slot_out_reg    <= slot_reg;
                        m_byte_offset_reg <= product[OFFSET_W-1:0];
                        m_status_reg      <= status_reg;
                        m_pages_used_reg  <= page_count_reg;
                        if (pop_reg) begin
                            head_reg        <= rd_data_reg;
                            handed_out_reg  <= handed_inc;
                            m_items_out_reg <= handed_inc;
                        end else begin
                            m_items_out_reg <= handed_out_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_slot_out    = m_slot_out_reg;
    assign m_byte_offset = m_byte_offset_reg;
    assign m_status      = m_status_reg;
    assign m_pages_used  = m_pages_used_reg;
    assign m_items_out   = m_items_out_reg;

endmodule
